@@ src/websocket_frame_receiver_defines.svh @@
// assertion macros for the frame receiver checker
// expects clk and rst_n to be visible where a macro is used
`ifndef WEBSOCKET_FRAME_RECEIVER_DEFINES_SVH
`define WEBSOCKET_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define WSR_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame receiver check failed");

// next-cycle implication, sampled on clk, off during reset
`define WSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame receiver check failed");

`endif

@@ src/wsr_pkg.sv @@
// shared types, codes and helper functions for the frame receiver
// no dependencies
package wsr_pkg;

    localparam int unsigned MAX_PAYLOAD_W = 31;
    localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RESET = 31'h7fff_ffff;
    localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_LOW   = 31'd1024;

    // parse phases
    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    // header byte counts
    localparam logic [3:0] HBC_LEN16 = 4'd2;
    localparam logic [3:0] HBC_LEN64 = 4'd8;
    localparam logic [3:0] HBC_MASK  = 4'd4;

    localparam logic [6:0] LEN7_MAX   = 7'd125;
    localparam logic [6:0] LEN7_EXT16 = 7'd126;

    // opcodes
    localparam logic [3:0] OP_CONT  = 4'd0;
    localparam logic [3:0] OP_TEXT  = 4'd1;
    localparam logic [3:0] OP_BIN   = 4'd2;
    localparam logic [3:0] OP_CLOSE = 4'd8;
    localparam logic [3:0] OP_PING  = 4'd9;
    localparam logic [3:0] OP_PONG  = 4'd10;

    // message kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_TEXT = 2'd1;
    localparam logic [1:0] KIND_BIN  = 2'd2;

    // event codes
    localparam logic [3:0] EV_NONE     = 4'd0;
    localparam logic [3:0] EV_HDR_DONE = 4'd1;
    localparam logic [3:0] EV_FRAG     = 4'd2;
    localparam logic [3:0] EV_MSG      = 4'd3;
    localparam logic [3:0] EV_PING     = 4'd4;
    localparam logic [3:0] EV_PONG     = 4'd5;
    localparam logic [3:0] EV_CLOSE    = 4'd6;
    localparam logic [3:0] EV_PROTO    = 4'd7;
    localparam logic [3:0] EV_TOO_BIG  = 4'd8;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic [3:0] frame_opcode;
        logic       frame_final;
        logic [2:0] reserved_bits;
        logic [1:0] message_kind;
        logic       frame_last;
        logic [3:0] event_res;
        logic       link_open;
    } res_t;

    typedef struct packed {
        logic [3:0] ev;
        logic [1:0] frag;
        logic       close;
    } done_t;

    function automatic logic [1:0] kind_of(input logic [3:0] op, input logic [1:0] frag);
        logic [1:0] k;
        if (op == OP_TEXT) k = KIND_TEXT;
        else if (op == OP_BIN) k = KIND_BIN;
        else k = frag;
        return k;
    endfunction

    // opcode rules applied when a frame completes
    function automatic done_t frame_done(input logic [3:0] op, input logic fin,
                                         input logic [1:0] frag);
        done_t d;
        d.frag = frag;
        d.ev   = EV_PROTO;
        unique case (op)
            OP_CONT:
            begin
                if (frag == KIND_NONE) d.ev = EV_PROTO;
                else if (fin)
                begin
                    d.frag = KIND_NONE;
                    d.ev   = EV_MSG;
                end
                else d.ev = EV_FRAG;
            end
            OP_TEXT, OP_BIN:
            begin
                if (fin) d.ev = EV_MSG;
                else if (frag != KIND_NONE) d.ev = EV_PROTO;
                else
                begin
                    d.frag = op[1:0];
                    d.ev   = EV_FRAG;
                end
            end
            OP_CLOSE: d.ev = EV_CLOSE;
            OP_PING:  d.ev = EV_PING;
            OP_PONG:  d.ev = EV_PONG;
            default:  d.ev = EV_PROTO;
        endcase
        d.close = (d.ev == EV_CLOSE) || (d.ev == EV_PROTO);
        return d;
    endfunction

endpackage

@@ src/wsr_in_stage.sv @@
// input register stage of the frame receiver
// no package use
module wsr_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       advance,
    output logic       fire,
    output logic [7:0] s1_byte
);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_byte_reg;

    assign in_stall      = s1_valid_reg && !advance;
    assign fire          = s1_valid_reg && advance;
    assign s1_valid_next = in_stall ? s1_valid_reg : in_valid;
    assign s1_byte       = s1_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_byte_reg <= data_byte;
    end

endmodule

@@ src/wsr_parser.sv @@
// frame header parser, unmasking and fragment tracking, one byte per transfer
// depends on wsr_pkg
module wsr_parser (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [wsr_pkg::MAX_PAYLOAD_W-1:0]  cfg_wr_data,
    input  logic                               fire,
    input  logic [7:0]                         s1_byte,
    output wsr_pkg::res_t                      res
);
    import wsr_pkg::*;

    logic [MAX_PAYLOAD_W-1:0] max_payload_reg;
    logic [2:0]  phase_reg,    phase_next;
    logic [3:0]  hbc_reg,      hbc_next;
    logic [63:0] len_reg,      len_next;
    logic [31:0] key_reg,      key_next;
    logic        mask_reg,     mask_next;
    logic [30:0] rem_reg,      rem_next;
    logic [1:0]  mphase_reg,   mphase_next;
    logic [3:0]  opcode_reg,   opcode_next;
    logic        fin_reg,      fin_next;
    logic [2:0]  rsv_reg,      rsv_next;
    logic [1:0]  frag_reg,     frag_next;
    logic        open_reg,     open_next;

    logic [3:0]  ev;
    logic [7:0]  ob;
    logic [7:0]  key_byte;
    logic        valid;
    logic        last;
    logic        len_done;
    logic        hdr_done;
    logic        pay_done;
    logic [1:0]  frag_mid;
    logic [1:0]  kind;
    done_t       done;

    always_comb
    begin
        unique case (mphase_reg)
            2'd0: key_byte = key_reg[31:24];
            2'd1: key_byte = key_reg[23:16];
            2'd2: key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        hbc_next    = hbc_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        mask_next   = mask_reg;
        rem_next    = rem_reg;
        mphase_next = mphase_reg;
        opcode_next = opcode_reg;
        fin_next    = fin_reg;
        rsv_next    = rsv_reg;
        open_next   = open_reg;
        ev          = EV_NONE;
        ob          = 8'd0;
        valid       = 1'b0;
        last        = 1'b0;
        len_done    = 1'b0;
        hdr_done    = 1'b0;
        pay_done    = 1'b0;
        frag_mid    = frag_reg;
        done        = frame_done(opcode_reg, fin_reg, frag_reg);

        if (open_reg)
        begin
            unique case (phase_reg)
                PH_HDR1:
                begin
                    mask_next = s1_byte[7];
                    if (s1_byte[6:0] <= LEN7_MAX)
                    begin
                        len_next = {57'd0, s1_byte[6:0]};
                        len_done = 1'b1;
                    end
                    else
                    begin
                        len_next   = 64'd0;
                        hbc_next   = (s1_byte[6:0] == LEN7_EXT16) ? HBC_LEN16 : HBC_LEN64;
                        phase_next = PH_EXTLEN;
                    end
                end
                PH_EXTLEN:
                begin
                    len_next = {len_reg[55:0], s1_byte};
                    hbc_next = hbc_reg - 4'd1;
                    len_done = (hbc_next == 4'd0);
                end
                PH_MASK:
                begin
                    key_next = {key_reg[23:0], s1_byte};
                    hbc_next = hbc_reg - 4'd1;
                    hdr_done = (hbc_next == 4'd0);
                end
                PH_PAYLOAD:
                begin
                    ob          = s1_byte ^ key_byte;
                    valid       = 1'b1;
                    mphase_next = mphase_reg + 2'd1;
                    rem_next    = rem_reg - 31'd1;
                    pay_done    = (rem_next == 31'd0);
                end
                default:
                begin
                    fin_next    = s1_byte[7];
                    rsv_next    = s1_byte[6:4];
                    opcode_next = s1_byte[3:0];
                    key_next    = 32'd0;
                    mask_next   = 1'b0;
                    mphase_next = 2'd0;
                    len_next    = 64'd0;
                    hbc_next    = 4'd0;
                    phase_next  = PH_HDR1;
                end
            endcase

            if (len_done)
            begin
                if (mask_next)
                begin
                    phase_next = PH_MASK;
                    hbc_next   = HBC_MASK;
                end
                else
                    hdr_done = 1'b1;
            end

            if (hdr_done)
            begin
                if (len_next > {33'd0, max_payload_reg})
                begin
                    open_next = 1'b0;
                    ev        = EV_TOO_BIG;
                end
                else if (len_next == 64'd0)
                begin
                    // empty payload completes the frame on the header byte
                    last       = 1'b1;
                    ev         = done.ev;
                    frag_mid   = done.frag;
                    phase_next = PH_HDR0;
                    if (done.close)
                        open_next = 1'b0;
                end
                else
                begin
                    rem_next   = len_next[30:0];
                    phase_next = PH_PAYLOAD;
                    ev         = EV_HDR_DONE;
                end
            end
        end

        kind      = kind_of(opcode_next, frag_mid);
        frag_next = frag_mid;

        if (pay_done)
        begin
            last       = 1'b1;
            ev         = done.ev;
            frag_next  = done.frag;
            phase_next = PH_HDR0;
            if (done.close)
                open_next = 1'b0;
        end
    end

    always_comb
    begin
        res.out_valid     = valid;
        res.out_byte      = ob;
        res.frame_opcode  = opcode_next;
        res.frame_final   = fin_next;
        res.reserved_bits = rsv_next;
        res.message_kind  = kind;
        res.frame_last    = last;
        res.event_res     = ev;
        res.link_open     = open_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_payload_reg <= MAX_PAYLOAD_RESET;
        else if (cfg_wr_en && (cfg_wr_data >= MAX_PAYLOAD_LOW))
            max_payload_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            hbc_reg    <= 4'd0;
            len_reg    <= 64'd0;
            key_reg    <= 32'd0;
            mask_reg   <= 1'b0;
            rem_reg    <= 31'd0;
            mphase_reg <= 2'd0;
            opcode_reg <= OP_CONT;
            fin_reg    <= 1'b0;
            rsv_reg    <= 3'd0;
            frag_reg   <= KIND_NONE;
            open_reg   <= 1'b1;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            hbc_reg    <= hbc_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
            mask_reg   <= mask_next;
            rem_reg    <= rem_next;
            mphase_reg <= mphase_next;
            opcode_reg <= opcode_next;
            fin_reg    <= fin_next;
            rsv_reg    <= rsv_next;
            frag_reg   <= frag_next;
            open_reg   <= open_next;
        end
    end

endmodule

@@ src/wsr_out_stage.sv @@
// result register stage of the frame receiver
// depends on wsr_pkg
module wsr_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  wsr_pkg::res_t res,
    output logic          advance,
    output logic          res_valid,
    input  logic          res_stall,
    output wsr_pkg::res_t res_q
);
    import wsr_pkg::*;

    logic res_valid_reg;
    logic res_valid_next;
    res_t res_reg;

    assign advance        = !res_valid_reg || !res_stall;
    assign res_valid_next = advance ? fire : res_valid_reg;
    assign res_valid      = res_valid_reg;
    assign res_q          = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res;
    end

endmodule

@@ src/websocket_frame_receiver.sv @@
// frame receiver top level: one received byte in, one result out per transfer
// path: an accepted byte is held in the input register, parsed, then held in the result register
// throughput: one byte per cycle while res_stall is low, set by the input and result registers
// reset: parser at first header byte, link open, max_payload back to its largest value
// depends on wsr_pkg, wsr_in_stage, wsr_parser, wsr_out_stage
module websocket_frame_receiver (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [wsr_pkg::MAX_PAYLOAD_W-1:0] cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        data_byte,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic                              out_valid,
    output logic [7:0]                        out_byte,
    output logic [3:0]                        frame_opcode,
    output logic                              frame_final,
    output logic [2:0]                        reserved_bits,
    output logic [1:0]                        message_kind,
    output logic                              frame_last,
    output logic [3:0]                        event_res,
    output logic                              link_open
);
    import wsr_pkg::*;

    logic       advance;
    logic       fire;
    logic [7:0] s1_byte;
    res_t       res;
    res_t       res_q;

    wsr_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .advance   (advance),
        .fire      (fire),
        .s1_byte   (s1_byte)
    );

    wsr_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .s1_byte     (s1_byte),
        .res         (res)
    );

    wsr_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .res       (res),
        .advance   (advance),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_q     (res_q)
    );

    assign out_valid     = res_q.out_valid;
    assign out_byte      = res_q.out_byte;
    assign frame_opcode  = res_q.frame_opcode;
    assign frame_final   = res_q.frame_final;
    assign reserved_bits = res_q.reserved_bits;
    assign message_kind  = res_q.message_kind;
    assign frame_last    = res_q.frame_last;
    assign event_res     = res_q.event_res;
    assign link_open     = res_q.link_open;

endmodule

@@ src/wsr_checker.sv @@
// port-level checks on the frame receiver results, with its bind
// depends on wsr_pkg and websocket_frame_receiver_defines.svh
`include "websocket_frame_receiver_defines.svh"

module wsr_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       res_valid,
    input  logic       res_stall,
    input  logic       out_valid,
    input  logic       frame_last,
    input  logic [3:0] event_res,
    input  logic       link_open
);
    import wsr_pkg::*;

    logic xfer;
    logic closed_reg;
    logic closed_next;
    logic quiet_ok;
    logic fatal_ev;
    logic last_ev_ok;

    assign xfer        = res_valid && !res_stall;
    assign closed_next = closed_reg || (xfer && !link_open);
    assign quiet_ok    = !link_open && !out_valid && (event_res == EV_NONE);
    assign fatal_ev    = (event_res == EV_CLOSE) || (event_res == EV_PROTO)
                         || (event_res == EV_TOO_BIG);
    assign last_ev_ok  = (event_res != EV_NONE) && (event_res != EV_HDR_DONE)
                         && (event_res != EV_TOO_BIG);

    // once a result has shown the link closed, it stays closed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            closed_reg <= 1'b0;
        else
            closed_reg <= closed_next;
    end

    `WSR_ASSERT_IMPLY(a_closed_quiet, xfer && closed_reg, quiet_ok)
    `WSR_ASSERT_IMPLY(a_fatal_closes, xfer && fatal_ev, !link_open)
    `WSR_ASSERT_IMPLY(a_last_event, xfer && frame_last, last_ev_ok)
    `WSR_ASSERT_NEXT(a_stall_holds, res_valid && res_stall, res_valid)

endmodule

bind websocket_frame_receiver wsr_checker u_wsr_checker (.*);
